// ===== rtl/fcas_pkg.sv =====
// Package for the function-call argument splitter.
// Holds character codes, the parse phase type and the result item type.
// No dependencies.
`timescale 1ns / 1ps

package fcas_pkg;

   localparam logic [15:0] CH_LPAR   = 16'h0028;
   localparam logic [15:0] CH_RPAR   = 16'h0029;
   localparam logic [15:0] CH_COMMA  = 16'h002C;
   localparam logic [15:0] CH_SEMI   = 16'h003B;
   localparam logic [15:0] CH_DQUOTE = 16'h0022;
   localparam logic [15:0] CH_BSLASH = 16'h005C;
   localparam logic [15:0] CH_SPACE  = 16'h0020;
   localparam logic [15:0] CH_TAB    = 16'h0009;
   localparam logic [15:0] CH_CR     = 16'h000D;

   localparam logic [7:0] MAX_ARGS_RESET = 8'd16;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic KIND_SPAN    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef enum logic [4:0] {
      PH_BEFORE_NAME = 5'b00001,
      PH_IN_NAME     = 5'b00010,
      PH_BEFORE_ARG  = 5'b00100,
      PH_IN_ARG      = 5'b01000,
      PH_STOPPED     = 5'b10000
   } phase_type;

   typedef struct packed {
      logic        result_kind;
      logic [15:0] span_start;
      logic [15:0] span_length;
      logic [7:0]  arg_count;
      logic        is_last;
   } result_type;

endpackage

// ===== rtl/function_call_argument_splitter_unit.sv =====
// Top level of the function-call argument splitter.
// Parser state, span arithmetic and a four-entry result queue.
// Depends on fcas_pkg.
`timescale 1ns / 1ps

// One character item is accepted per cycle while req_stall is low. Each
// item updates the parse state in the same cycle and pushes zero, one or
// two result items (a span and, for the end marker, a summary) into a
// four-entry output queue, from which one result item leaves per cycle
// while rsp_stall is low. req_stall rises only when the queue holds more
// than two results. max_args is written through the csr_ channel, which
// is always ready.
module function_call_argument_splitter_unit #(
   parameter int MAX_CHARS = 65536,
   parameter int MAX_NEST  = 255
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_char_code,
   input  logic        req_end_of_string,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_result_kind,
   output logic [15:0] rsp_span_start,
   output logic [15:0] rsp_span_length,
   output logic [7:0]  rsp_arg_count,
   output logic        rsp_is_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_max_args
);

   localparam logic [15:0] PosMax  = 16'(MAX_CHARS - 1);
   localparam logic [7:0]  NestMax = 8'(MAX_NEST);
   localparam int          CntW    = fcas_pkg::QUEUE_CNT_W;

   logic [7:0]            max_args_ff;
   fcas_pkg::phase_type   phase_ff, phase_in;
   logic [7:0]            nest_ff, nest_in;
   logic                  quote_ff, quote_in;
   logic [15:0]           prev_ff, prev_in;
   logic [15:0]           pos_ff, pos_in;
   logic [15:0]           begin_ff, begin_in;
   logic                  oq_ff, oq_in;
   logic [7:0]            args_ff, args_in;

   fcas_pkg::result_type  queue_ff [fcas_pkg::QUEUE_DEPTH];
   fcas_pkg::result_type  queue_in [fcas_pkg::QUEUE_DEPTH];
   logic [CntW-1:0]       count_ff, count_in;

   logic                  accept, pop, blank, add_ok, add_req, emit, off;
   logic [15:0]           c, add_begin, add_len, span_len;
   logic                  add_oq;
   logic [7:0]            nest_upd;
   fcas_pkg::result_type  span_item, sum_item, first_item;
   logic [1:0]            n_push;
   logic [CntW-1:0]       cnt_after;

   assign csr_ready = 1'b1;
   assign req_stall = count_ff > CntW'(fcas_pkg::QUEUE_DEPTH - 2);
   assign accept    = req_valid & ~req_stall;
   assign rsp_valid = count_ff != '0;
   assign pop       = rsp_valid & ~rsp_stall;

   assign c      = req_end_of_string ? fcas_pkg::CH_COMMA : req_char_code;
   assign blank  = (c == fcas_pkg::CH_SPACE) ||
                   (c >= fcas_pkg::CH_TAB && c <= fcas_pkg::CH_CR);
   assign add_ok = args_ff < max_args_ff;

   always_comb begin
      phase_in  = phase_ff;
      nest_in   = nest_ff;
      quote_in  = quote_ff;
      begin_in  = begin_ff;
      oq_in     = oq_ff;
      add_req   = 1'b0;
      add_begin = begin_ff;
      add_len   = pos_ff - begin_ff;
      add_oq    = oq_ff;
      nest_upd  = nest_ff;
      unique case (phase_ff)
         fcas_pkg::PH_BEFORE_NAME: begin
            if (!blank && c != fcas_pkg::CH_SEMI && c != fcas_pkg::CH_DQUOTE) begin
               begin_in = pos_ff;
               oq_in    = 1'b0;
               phase_in = fcas_pkg::PH_IN_NAME;
            end
         end
         fcas_pkg::PH_IN_NAME: begin
            if (c == fcas_pkg::CH_LPAR && nest_ff == '0) begin
               nest_in  = 8'd1;
               add_req  = 1'b1;
               phase_in = add_ok ? fcas_pkg::PH_BEFORE_ARG : fcas_pkg::PH_STOPPED;
            end
         end
         fcas_pkg::PH_BEFORE_ARG: begin
            if (!blank) begin
               if (c == fcas_pkg::CH_RPAR || c == fcas_pkg::CH_COMMA) begin
                  if (c == fcas_pkg::CH_RPAR && nest_ff != '0) begin
                     nest_in = nest_ff - 8'd1;
                  end
                  add_req   = 1'b1;
                  add_begin = pos_ff;
                  add_len   = '0;
                  add_oq    = 1'b0;
                  if (!add_ok || c == fcas_pkg::CH_RPAR) begin
                     phase_in = fcas_pkg::PH_STOPPED;
                  end
               end else begin
                  quote_in = c == fcas_pkg::CH_DQUOTE;
                  oq_in    = c == fcas_pkg::CH_DQUOTE;
                  begin_in = pos_ff;
                  phase_in = fcas_pkg::PH_IN_ARG;
               end
            end
         end
         fcas_pkg::PH_IN_ARG: begin
            if (c == fcas_pkg::CH_RPAR) begin
               if (!quote_ff && nest_ff != '0) begin
                  nest_upd = nest_ff - 8'd1;
               end
            end else if (c == fcas_pkg::CH_LPAR) begin
               if (!quote_ff && nest_ff < NestMax) begin
                  nest_upd = nest_ff + 8'd1;
               end
            end
            nest_in = nest_upd;
            if ((c == fcas_pkg::CH_RPAR && nest_upd == '0) ||
                (c == fcas_pkg::CH_COMMA && nest_upd == 8'd1)) begin
               if (!quote_ff) begin
                  add_req  = 1'b1;
                  phase_in = (!add_ok || c == fcas_pkg::CH_RPAR) ?
                             fcas_pkg::PH_STOPPED : fcas_pkg::PH_BEFORE_ARG;
               end
            end else if (prev_ff != fcas_pkg::CH_BSLASH && c == fcas_pkg::CH_DQUOTE) begin
               quote_in = ~quote_ff;
            end
         end
         fcas_pkg::PH_STOPPED: begin
         end
         default: begin
         end
      endcase
   end

   assign emit     = add_req & add_ok;
   assign off      = (add_len != '0) && add_oq && (prev_ff == fcas_pkg::CH_DQUOTE);
   assign span_len = (add_len >= {14'd0, off, 1'b0}) ? add_len - {14'd0, off, 1'b0} : '0;
   assign args_in  = args_ff + {7'd0, emit};
   assign prev_in  = c;
   assign pos_in   = (pos_ff < PosMax) ? pos_ff + 16'd1 : pos_ff;

   always_comb begin
      span_item.result_kind = fcas_pkg::KIND_SPAN;
      span_item.span_start  = add_begin + {15'd0, off};
      span_item.span_length = span_len;
      span_item.arg_count   = args_in;
      span_item.is_last     = 1'b0;
      sum_item.result_kind  = fcas_pkg::KIND_SUMMARY;
      sum_item.span_start   = '0;
      sum_item.span_length  = '0;
      sum_item.arg_count    = args_in;
      sum_item.is_last      = 1'b1;
   end

   assign first_item = emit ? span_item : sum_item;
   assign n_push     = accept ? ({1'b0, emit} + {1'b0, req_end_of_string}) : 2'd0;
   assign cnt_after  = count_ff - {{(CntW-1){1'b0}}, pop};
   assign count_in   = cnt_after + CntW'(n_push);

   always_comb begin
      for (int k = 0; k < fcas_pkg::QUEUE_DEPTH; k++) begin
         if (pop && k < fcas_pkg::QUEUE_DEPTH - 1) begin
            queue_in[k] = queue_ff[k+1];
         end else begin
            queue_in[k] = queue_ff[k];
         end
         if (n_push != 2'd0 && CntW'(k) == cnt_after) begin
            queue_in[k] = first_item;
         end else if (n_push == 2'd2 && CntW'(k) == cnt_after + CntW'(1)) begin
            queue_in[k] = sum_item;
         end
      end
   end

   always_ff @(posedge clock) begin
      queue_ff <= queue_in;
      if (reset) begin
         count_ff    <= '0;
         max_args_ff <= fcas_pkg::MAX_ARGS_RESET;
         phase_ff    <= fcas_pkg::PH_BEFORE_NAME;
         nest_ff     <= '0;
         quote_ff    <= 1'b0;
         prev_ff     <= '0;
         pos_ff      <= '0;
         begin_ff    <= '0;
         oq_ff       <= 1'b0;
         args_ff     <= '0;
      end else begin
         count_ff <= count_in;
         if (csr_valid && csr_ready) begin
            max_args_ff <= csr_max_args;
         end
         if (accept) begin
            if (req_end_of_string) begin
               phase_ff <= fcas_pkg::PH_BEFORE_NAME;
               nest_ff  <= '0;
               quote_ff <= 1'b0;
               prev_ff  <= '0;
               pos_ff   <= '0;
               begin_ff <= '0;
               oq_ff    <= 1'b0;
               args_ff  <= '0;
            end else begin
               phase_ff <= phase_in;
               nest_ff  <= nest_in;
               quote_ff <= quote_in;
               prev_ff  <= prev_in;
               pos_ff   <= pos_in;
               begin_ff <= begin_in;
               oq_ff    <= oq_in;
               args_ff  <= args_in;
            end
         end
      end
   end

   assign rsp_result_kind = queue_ff[0].result_kind;
   assign rsp_span_start  = queue_ff[0].span_start;
   assign rsp_span_length = queue_ff[0].span_length;
   assign rsp_arg_count   = queue_ff[0].arg_count;
   assign rsp_is_last     = queue_ff[0].is_last;

endmodule

// ===== rtl/fcas_checker.sv =====
// Port-level checks for the function-call argument splitter.
// Bound to function_call_argument_splitter_unit; no package use.
`timescale 1ns / 1ps

module fcas_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_result_kind,
   input logic [15:0] rsp_span_start,
   input logic [15:0] rsp_span_length,
   input logic [7:0]  rsp_arg_count,
   input logic        rsp_is_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result item dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_span_start) && $stable(rsp_span_length)
                                 && $stable(rsp_arg_count) && $stable(rsp_is_last))
      else $error("stalled result item changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("queue not empty after reset");

   a_summary_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_result_kind == rsp_is_last) &&
                    (!rsp_is_last || (rsp_span_start == 16'd0 && rsp_span_length == 16'd0)) &&
                    (rsp_is_last || rsp_arg_count != 8'd0))
      else $error("malformed result item");

endmodule

bind function_call_argument_splitter_unit fcas_checker u_fcas_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_result_kind (rsp_result_kind),
   .rsp_span_start  (rsp_span_start),
   .rsp_span_length (rsp_span_length),
   .rsp_arg_count   (rsp_arg_count),
   .rsp_is_last     (rsp_is_last)
);
